@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sirt_pkg.sv @@
`timescale 1ns / 1ps

package sirt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam int TW = 12;
   localparam int RW = 16;

   localparam int HOURS_PER_DAY = 24;
   localparam int TIME_SCALE = 100;
   localparam logic [TW-1:0] MAX_TIME = TW'(HOURS_PER_DAY * TIME_SCALE);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_CONFLICT = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [TW-1:0] start_time;
      logic [TW-1:0] stop_time;
      logic [RW-1:0] room;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/sirt_ram.sv @@
`timescale 1ns / 1ps

module sirt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sorted_interval_reservation_table_core.sv @@
`timescale 1ns / 1ps
// Sorted interval reservation table.
// req_ channel: one transfer per reservation (begin time, end time, room tag).
// rsp_ channel: exactly one transfer per request (status, slot position,
// entry count after the request).
// Entries are kept in time order in a single-port-read, single-port-write RAM
// with a registered read. A binary search over the RAM finds the gap; later
// entries are then moved up one place, one entry per cycle, and the new entry
// is written.
// An invalid request goes straight to the result, and an insert into an empty
// table straight to the write. Otherwise the search probes run first, then the
// final check of the entries at lo and hi, then any moves and the write; a
// conflict at a probe or at the final check, or a full table, ends it early.
// One request is in work at a time: req_stall is high from the accepting edge
// until the result is loaded into the output register, so the next transfer can
// come in the same cycle that rsp_valid rises.
// A result waiting under rsp_stall does not block the next request transfer; the
// block then holds its finished result internally until the output register frees.
// Reset (synchronous) empties the table; RAM contents need no clearing.

`include "assert_macros.svh"

module sorted_interval_reservation_table_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_begin_time,
   input  logic [11:0]        req_end_time,
   input  logic signed [15:0] req_room_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_slot_position,
   output logic [6:0]         rsp_entry_count
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_PROBE   = 3'd2;
   localparam logic [2:0] S_READ_HI = 3'd3;
   localparam logic [2:0] S_FINAL   = 3'd4;
   localparam logic [2:0] S_SHIFT   = 3'd5;
   localparam logic [2:0] S_WRITE   = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   localparam int AW = sirt_pkg::AW;
   localparam int CW = sirt_pkg::CW;
   localparam int TW = sirt_pkg::TW;
   localparam logic [CW-1:0] DEPTH_C = CW'(sirt_pkg::TABLE_DEPTH);

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TW-1:0]       nb_ff, nb_in;
   logic [TW-1:0]       ne_ff, ne_in;
   logic [15:0]         room_ff, room_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic [AW-1:0]       mid_ff, mid_in;
   logic [TW-1:0]       lo_start_ff, lo_start_in;
   logic [TW-1:0]       lo_stop_ff, lo_stop_in;
   logic [CW-1:0]       gap_ff, gap_in;
   logic [AW-1:0]       rp_ff, rp_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       dst_ff, dst_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [6:0]          rsp_pos_ff, rsp_pos_in;
   logic [6:0]          rsp_count_ff, rsp_count_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [sirt_pkg::ENTRY_W-1:0] wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [sirt_pkg::ENTRY_W-1:0] rd_data;
   sirt_pkg::entry_type      rd_entry;
   sirt_pkg::entry_type      new_entry;

   logic [AW:0]   lohi_sum;
   logic [CW-1:0] last_idx;
   logic          req_xfer;
   logic          rsp_xfer;
   logic          invalid;

   sirt_ram #(
      .WIDTH (sirt_pkg::ENTRY_W),
      .DEPTH (sirt_pkg::TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry  = rd_data;
   assign new_entry = '{start_time: nb_ff, stop_time: ne_ff, room: room_ff};

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign lohi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign last_idx  = count_ff - CW'(1);
   assign invalid   = (req_begin_time > sirt_pkg::MAX_TIME) ||
                      (req_end_time > sirt_pkg::MAX_TIME) || req_room_tag[15];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      nb_in         = nb_ff;
      ne_in         = ne_ff;
      room_in       = room_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      lo_start_in   = lo_start_ff;
      lo_stop_in    = lo_stop_ff;
      gap_in        = gap_ff;
      rp_in         = rp_ff;
      rem_in        = rem_ff;
      pend_in       = 1'b0;
      dst_in        = dst_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = lo_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               nb_in         = req_begin_time;
               ne_in         = req_end_time;
               room_in       = req_room_tag;
               res_status_in = sirt_pkg::ST_OK;
               lo_in         = '0;
               hi_in         = AW'(last_idx);
               gap_in        = '0;
               if (invalid) begin
                  res_status_in = sirt_pkg::ST_INVALID;
                  state_in      = S_DONE;
               end else if (count_ff == '0) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            rd_en = 1'b1;
            if ((hi_ff - lo_ff) > AW'(1)) begin
               mid_in   = lohi_sum[AW:1];
               rd_addr  = lohi_sum[AW:1];
               state_in = S_PROBE;
            end else begin
               rd_addr  = lo_ff;
               state_in = S_READ_HI;
            end
         end
         S_PROBE: begin
            state_in = S_SEARCH;
            if (nb_ff >= rd_entry.stop_time) begin
               lo_in = mid_ff;
            end else if (ne_ff <= rd_entry.start_time) begin
               hi_in = mid_ff;
            end else begin
               res_status_in = sirt_pkg::ST_CONFLICT;
               state_in      = S_DONE;
            end
         end
         S_READ_HI: begin
            lo_start_in = rd_entry.start_time;
            lo_stop_in  = rd_entry.stop_time;
            rd_en       = 1'b1;
            rd_addr     = hi_ff;
            state_in    = S_FINAL;
         end
         S_FINAL: begin
            state_in = S_DONE;
            if (nb_ff >= lo_stop_ff && ne_ff <= rd_entry.start_time) begin
               gap_in = CW'(hi_ff);
            end else if (nb_ff >= rd_entry.stop_time && CW'(hi_ff) == last_idx) begin
               gap_in = count_ff;
            end else if (ne_ff <= lo_start_ff && lo_ff == '0) begin
               gap_in = '0;
            end else begin
               res_status_in = sirt_pkg::ST_CONFLICT;
            end
            if (res_status_in == sirt_pkg::ST_OK) begin
               if (count_ff == DEPTH_C) begin
                  res_status_in = sirt_pkg::ST_FULL;
               end else if (gap_in == count_ff) begin
                  state_in = S_WRITE;
               end else begin
                  rp_in    = AW'(last_idx);
                  rem_in   = count_ff - gap_in;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            wr_en   = pend_ff;
            wr_addr = dst_ff;
            wr_data = rd_data;
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = rp_ff;
               dst_in  = rp_ff + AW'(1);
               pend_in = 1'b1;
               rp_in   = rp_ff - AW'(1);
               rem_in  = rem_ff - CW'(1);
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(gap_ff);
            wr_data  = new_entry;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = (res_status_ff == sirt_pkg::ST_OK) ? 7'(gap_ff) : 7'd0;
               rsp_count_in  = 7'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_ff         <= nb_in;
      ne_ff         <= ne_in;
      room_ff       <= room_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      lo_start_ff   <= lo_start_in;
      lo_stop_ff    <= lo_stop_in;
      gap_ff        <= gap_in;
      rp_ff         <= rp_in;
      rem_ff        <= rem_in;
      dst_ff        <= dst_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_position = rsp_pos_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `ASSERT_SAME(a_count_bound, 1'b1, count_ff <= DEPTH_C, "entry count above table depth")
   `ASSERT_SAME(a_rw_hazard, wr_en && rd_en, wr_addr != rd_addr, "read and write hit one entry")
   `ASSERT_SAME(a_search_order, state_ff == S_SEARCH, lo_ff <= hi_ff, "search bounds crossed")
   `ASSERT_SAME(a_write_slot, state_ff == S_WRITE,
                gap_ff <= count_ff && count_ff < DEPTH_C, "insert slot out of range")
   `ASSERT_NEXT(a_insert_count, state_ff == S_WRITE,
                count_ff == $past(count_ff) + CW'(1), "count not bumped on insert")

endmodule

@@ tb/sorted_interval_reservation_table_core_tb.sv @@
`timescale 1ns / 1ps

localparam int NO_GAP = -1;

typedef struct {
   logic [1:0] status;
   logic [6:0] slot;
   logic [6:0] count;
} reply_type;

class reservation_book;
   sirt_pkg::entry_type slots[sirt_pkg::TABLE_DEPTH];
   int        fill;
   reply_type awaited[$];
   int        faults;

   function new();
      fill = 0;
      faults = 0;
   endfunction

   // binary search for a gap, conflict if a probe overlaps
   function int find_free_gap(logic [11:0] nb, logic [11:0] ne);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = fill - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (nb >= slots[mid].stop_time) begin
            lo = mid;
         end else if (ne <= slots[mid].start_time) begin
            hi = mid;
         end else begin
            return NO_GAP;
         end
      end
      if (nb >= slots[lo].stop_time && ne <= slots[hi].start_time) return hi;
      if (nb >= slots[hi].stop_time && hi == fill - 1) return fill;
      if (ne <= slots[lo].start_time && lo == 0) return 0;
      return NO_GAP;
   endfunction

   function void note_request(logic [11:0] nb, logic [11:0] ne, logic [15:0] room);
      reply_type want;
      int     gap;
      int     i;
      want.status = sirt_pkg::ST_OK;
      want.slot = '0;
      if (nb > sirt_pkg::MAX_TIME || ne > sirt_pkg::MAX_TIME || room[15]) begin
         want.status = sirt_pkg::ST_INVALID;
      end else begin
         gap = (fill > 0) ? find_free_gap(nb, ne) : 0;
         if (gap == NO_GAP) begin
            want.status = sirt_pkg::ST_CONFLICT;
         end else if (fill >= sirt_pkg::TABLE_DEPTH) begin
            want.status = sirt_pkg::ST_FULL;
         end else begin
            for (i = fill; i > gap; i--) slots[i] = slots[i - 1];
            slots[gap].start_time = nb;
            slots[gap].stop_time = ne;
            slots[gap].room = room;
            fill++;
            want.slot = 7'(gap);
         end
      end
      want.count = 7'(fill);
      awaited.push_back(want);
   endfunction

   function void check_reply(logic [1:0] status, logic [6:0] slot, logic [6:0] count);
      reply_type want;
      if (awaited.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("%0t: unexpected result status %0d slot %0d count %0d",
                     $time, status, slot, count);
         return;
      end
      want = awaited.pop_front();
      if (status !== want.status || slot !== want.slot || count !== want.count) begin
         faults++;
         if (faults <= 10)
            $display("%0t: exp status %0d slot %0d count %0d, got %0d %0d %0d",
                     $time, want.status, want.slot, want.count, status, slot, count);
      end
   endfunction
endclass

module sorted_interval_reservation_table_core_tb;

   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [11:0]        req_begin_time = '0;
   logic [11:0]        req_end_time = '0;
   logic signed [15:0] req_room_tag = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_slot_position;
   logic [6:0]         rsp_entry_count;

   reservation_book book = new();
   bit  idle_on = 1'b1;
   int  stall_left = 0;
   int  quiet = 0;
   int  corner_times[4] = '{0, 2400, 2401, 4095};

   sorted_interval_reservation_table_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_begin_time    (req_begin_time),
      .req_end_time      (req_end_time),
      .req_room_tag      (req_room_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_position (rsp_slot_position),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: stall drawn per transfer, counted down while a result waits
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            book.check_reply(rsp_status, rsp_slot_position, rsp_entry_count);
            stall_left = idle_on ? $urandom_range(0, 4) : 0;
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("sorted_interval_reservation_table_core: mismatch");
         $finish;
      end
   end

   task automatic send_req(input logic [11:0] b, input logic [11:0] e, input logic [15:0] r);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_begin_time <= b;
      req_end_time <= e;
      req_room_tag <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(b, e, r);
   endtask

   initial begin
      int        n;
      int        kind;
      int        bi;
      int        ei;
      int        len;
      int        k;
      logic [15:0] r;
      sirt_pkg::entry_type s;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_req(12'd100, 12'd200, 16'd0);        // empty table
      send_req(12'd200, 12'd300, 16'd7);        // touching end
      send_req(12'd0, 12'd100, 16'd3);          // touching begin
      send_req(12'd150, 12'd250, 16'd1);        // overlap
      send_req(12'd120, 12'd180, 16'd1);        // overlaps probe
      send_req(12'd2401, 12'd2400, 16'd0);      // begin out of range
      send_req(12'd10, 12'd4095, 16'd0);        // end out of range
      send_req(12'd500, 12'd600, 16'hFFFF);     // negative room
      send_req(12'd500, 12'd600, 16'h8000);
      send_req(12'd4095, 12'd4095, 16'h7FFF);
      send_req(12'd2400, 12'd2400, 16'h7FFF);   // latest time
      send_req(12'd350, 12'd320, 16'd9);        // begin after end
      send_req(12'd0, 12'd0, 16'd0);            // zero length at start
      send_req(12'd250, 12'd2400, 16'd2);       // spans several entries
      send_req(12'd2400, 12'd0, 16'd5);
      send_req(12'd1000, 12'd1000, 16'd4);
      send_req(12'd1000, 12'd1000, 16'd4);      // identical zero length
      send_req(12'd300, 12'd320, 16'd6);

      // random: mostly short intervals, some placed next to stored ones
      for (n = 0; n < 1700; n++) begin
         if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         r = 16'($urandom_range(0, 32767));
         len = $urandom_range(0, 30);
         if (kind < 40) begin
            bi = $urandom_range(0, 2400);
            ei = (bi + len > 2400) ? 2400 : bi + len;
         end else if (kind < 60 && book.fill > 0) begin
            k = $urandom_range(0, book.fill - 1);
            s = book.slots[k];
            if ($urandom_range(0, 1) == 1) begin
               bi = s.stop_time;
               ei = (bi + len > 2400) ? 2400 : bi + len;
            end else begin
               ei = s.start_time;
               bi = (ei >= len) ? ei - len : 0;
            end
         end else if (kind < 68) begin
            bi = $urandom_range(1, 2400);
            ei = $urandom_range(0, bi - 1);
         end else if (kind < 78) begin
            bi = $urandom_range(0, 2400);
            ei = $urandom_range(0, 2400);
            case ($urandom_range(0, 2))
               0: bi = $urandom_range(2401, 4095);
               1: ei = $urandom_range(2401, 4095);
               default: r = 16'h8000 | 16'($urandom);
            endcase
         end else if (kind < 90) begin
            bi = $urandom_range(0, 4095);
            ei = $urandom_range(0, 4095);
            r = 16'($urandom);
         end else begin
            bi = corner_times[$urandom_range(0, 3)];
            ei = corner_times[$urandom_range(0, 3)];
            if ($urandom_range(0, 3) == 0) r = 16'h7FFF;
         end
         send_req(12'(bi), 12'(ei), r);
      end
      req_valid <= 1'b0;

      while (book.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (book.faults == 0 && book.awaited.size() == 0) begin
         $display("sorted_interval_reservation_table_core: match");
      end else begin
         $display("sorted_interval_reservation_table_core: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sirt_pkg.sv
rtl/sirt_ram.sv
rtl/sorted_interval_reservation_table_core.sv
tb/sorted_interval_reservation_table_core_tb.sv
